FILE: rtl/lsil_pkg.sv
// ============================================================================
// lsil_pkg
// Shared types and constants for the line start index and lookup block.
// ============================================================================
`default_nettype none

package lsil_pkg;

    // Table depth and offset width.
    localparam int MAX_LINES   = 4096;
    localparam int OFFSET_BITS = 24;

    // Table address, line count and line number widths.
    localparam int ADDR_BITS = $clog2(MAX_LINES);
    localparam int CNT_BITS  = $clog2(MAX_LINES + 1);

    // Line break characters.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Request kinds carried on the action field.
    typedef enum logic [1:0] {
        ACT_BEGIN = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_END   = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    // Newline recogniser states.
    typedef enum logic [1:0] {
        SCAN_PLAIN = 2'd0,
        SCAN_CR    = 2'd1,
        SCAN_LF    = 2'd2
    } scan_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // a request is taken this cycle
        logic first;    // first table entry is on the read data
        logic step;     // one binary search step
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;   // the table holds no starts
        logic first_done;   // query is answered by the first entry
        logic step_done;    // search span has shrunk to one entry
        logic out_busy;     // result register full and stalled
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/lsil_ctrl.sv
// ============================================================================
// lsil_ctrl
// Controller: sequences stream requests and the multi-cycle table search.
// ============================================================================
`default_nettype none

module lsil_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       action,
    output logic                  in_stall,
    input  wire lsil_pkg::status_t status,
    output lsil_pkg::cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_FIRST  = 3'b010,
        ST_SEARCH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_query;

    assign is_query = (lsil_pkg::action_t'(action) == lsil_pkg::ACT_QUERY);

    // A query needs a free result register; other requests never produce one.
    assign in_stall = (state_reg != ST_IDLE) || (status.out_busy && is_query);

    always_comb
    begin
        cmd.accept = in_valid && !in_stall;
        cmd.first  = (state_reg == ST_FIRST);
        cmd.step   = (state_reg == ST_SEARCH);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && is_query && !status.count_zero)
                begin
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                state_next = status.first_done ? ST_IDLE : ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (status.step_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lsil_dp.sv
// ============================================================================
// lsil_dp
// Datapath: newline recogniser, line start table and binary search unit.
// ============================================================================
`default_nettype none

module lsil_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [1:0]                       action,
    input  wire logic [7:0]                       byte_value,
    input  wire logic [lsil_pkg::OFFSET_BITS-1:0] query_offset,
    input  wire lsil_pkg::cmd_t                   cmd,
    output lsil_pkg::status_t                     status,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [lsil_pkg::CNT_BITS-1:0]         line,
    output logic [lsil_pkg::OFFSET_BITS-1:0]      column,
    output logic                                  table_overflow
);

    localparam int AW = lsil_pkg::ADDR_BITS;
    localparam int CW = lsil_pkg::CNT_BITS;
    localparam int OW = lsil_pkg::OFFSET_BITS;

    // Line start table; contents are undefined until written.
    logic [OW-1:0] table_mem [lsil_pkg::MAX_LINES];
    logic [OW-1:0] rdata_reg;

    // Stream state.
    logic [CW-1:0]       count_reg,  count_next;
    lsil_pkg::scan_t     scan_reg,   scan_next;
    logic [OW-1:0]       pos_reg,    pos_next;
    logic                ovf_reg,    ovf_next;

    // Search state.
    logic [OW-1:0] off_reg,  off_next;
    logic [AW-1:0] i_reg,    i_next;
    logic [AW-1:0] k_reg,    k_next;
    logic [CW-1:0] s_reg,    s_next;
    logic [OW-1:0] base_reg, base_next;

    // Result register.
    logic          res_valid_reg, res_valid_next;
    logic [CW-1:0] res_line_reg,  res_line_next;
    logic [OW-1:0] res_col_reg,   res_col_next;
    logic          res_ovf_reg,   res_ovf_next;

    lsil_pkg::action_t act;
    lsil_pkg::scan_t   cls;
    logic              starts;
    logic              record;
    logic              room;
    logic              wr_en;
    logic [AW-1:0]     rd_addr;
    logic              take;
    logic [AW-1:0]     i_new;
    logic [OW-1:0]     base_new;
    logic [CW-1:0]     s_new;
    logic [CW-1:0]     half0;
    logic [CW-1:0]     half_new;
    logic [AW-1:0]     k_new;
    logic              below;
    logic              single;
    logic              res_load;

    always_comb
    begin
        act = lsil_pkg::action_t'(action);

        if (byte_value == lsil_pkg::CH_CR)
        begin
            cls = lsil_pkg::SCAN_CR;
        end
        else if (byte_value == lsil_pkg::CH_LF)
        begin
            cls = lsil_pkg::SCAN_LF;
        end
        else
        begin
            cls = lsil_pkg::SCAN_PLAIN;
        end

        // After CR every byte but LF opens a line; after LF every byte does.
        case (scan_reg)
            lsil_pkg::SCAN_CR: starts = (cls != lsil_pkg::SCAN_LF);
            lsil_pkg::SCAN_LF: starts = 1'b1;
            default:           starts = 1'b0;
        endcase

        record = cmd.accept &&
                 (((act == lsil_pkg::ACT_BYTE) && starts) ||
                  ((act == lsil_pkg::ACT_END) && (scan_reg != lsil_pkg::SCAN_PLAIN)));
        room  = (count_reg < CW'(lsil_pkg::MAX_LINES));
        wr_en = record && room;

        count_next = count_reg;
        scan_next  = scan_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        off_next   = off_reg;

        if (cmd.accept)
        begin
            case (act)
                lsil_pkg::ACT_BEGIN:
                begin
                    count_next = '0;
                    scan_next  = lsil_pkg::SCAN_PLAIN;
                    pos_next   = '0;
                    ovf_next   = 1'b0;
                end
                lsil_pkg::ACT_BYTE:
                begin
                    scan_next = cls;
                    if (pos_reg != {OW{1'b1}})
                    begin
                        pos_next = pos_reg + OW'(1);
                    end
                end
                lsil_pkg::ACT_END:
                begin
                    scan_next = lsil_pkg::SCAN_PLAIN;
                end
                lsil_pkg::ACT_QUERY:
                begin
                    off_next = query_offset;
                end
                default:
                begin
                    off_next = off_reg;
                end
            endcase
            if (record)
            begin
                if (room)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        // First check against entry zero.
        below  = (off_reg < rdata_reg);
        single = (count_reg == CW'(1));
        half0  = count_reg >> 1;

        // One search step: the probed entry is on the read data.
        take     = (rdata_reg <= off_reg);
        i_new    = take ? k_reg : i_reg;
        base_new = take ? rdata_reg : base_reg;
        s_new    = s_reg - (s_reg >> 1);
        half_new = s_new >> 1;
        k_new    = i_new + half_new[AW-1:0];

        i_next    = i_reg;
        k_next    = k_reg;
        s_next    = s_reg;
        base_next = base_reg;
        rd_addr   = '0;

        if (cmd.first)
        begin
            i_next    = '0;
            k_next    = half0[AW-1:0];
            s_next    = count_reg;
            base_next = rdata_reg;
            rd_addr   = half0[AW-1:0];
        end
        else if (cmd.step)
        begin
            i_next    = i_new;
            k_next    = k_new;
            s_next    = s_new;
            base_next = base_new;
            rd_addr   = k_new;
        end

        res_load      = 1'b0;
        res_line_next = res_line_reg;
        res_col_next  = res_col_reg;
        if (cmd.accept && (act == lsil_pkg::ACT_QUERY) && (count_reg == '0))
        begin
            res_load      = 1'b1;
            res_line_next = '0;
            res_col_next  = query_offset;
        end
        else if (cmd.first && below)
        begin
            res_load      = 1'b1;
            res_line_next = '0;
            res_col_next  = off_reg;
        end
        else if (cmd.first && single)
        begin
            res_load      = 1'b1;
            res_line_next = CW'(1);
            res_col_next  = off_reg - rdata_reg;
        end
        else if (cmd.step && (s_new <= CW'(1)))
        begin
            res_load      = 1'b1;
            res_line_next = CW'(i_new) + CW'(1);
            res_col_next  = off_reg - base_new;
        end
        res_ovf_next = res_load ? ovf_reg : res_ovf_reg;

        res_valid_next = res_valid_reg && out_stall;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end

        status.count_zero = (count_reg == '0);
        status.first_done = below || single;
        status.step_done  = (s_new <= CW'(1));
        status.out_busy   = res_valid_reg && out_stall;
    end

    // Table: one write port for the scanner, one registered read port for search.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[count_reg[AW-1:0]] <= pos_reg;
        end
        rdata_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_reg      <= lsil_pkg::SCAN_PLAIN;
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            pos_reg       <= pos_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg      <= off_next;
        i_reg        <= i_next;
        k_reg        <= k_next;
        s_reg        <= s_next;
        base_reg     <= base_next;
        res_line_reg <= res_line_next;
        res_col_reg  <= res_col_next;
        res_ovf_reg  <= res_ovf_next;
    end

    assign out_valid      = res_valid_reg;
    assign line           = res_line_reg;
    assign column         = res_col_reg;
    assign table_overflow = res_ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/line_start_index_and_lookup.sv
// ============================================================================
// line_start_index_and_lookup
// Records the start offset of every source line and answers line and column
// queries for byte offsets by binary search of the recorded starts.
// ============================================================================
//
//  Channel  Direction  Handshake          Payload
//  -------  ---------  -----------------  -------------------------------------
//  in       sink       in_valid/in_stall  action, byte_value, query_offset
//  out      source     out_valid/out_stall line, column, table_overflow
//
// Begin, byte and end requests are taken back to back while no query search
// is in progress. A query against an empty table loads the result register
// in its acceptance cycle; otherwise it reads entry zero and then takes one
// binary search step per halving of the line count, each step reading through
// the single registered read port of the line start table.
// Reset clears the counters, recogniser and flags; the table itself is not
// cleared, as only entries below the line count are ever read.
// Only queries wait for a stalled result; other requests pass while it waits.
//
`default_nettype none

module line_start_index_and_lookup (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [1:0]                       action,
    input  wire logic [7:0]                       byte_value,
    input  wire logic [lsil_pkg::OFFSET_BITS-1:0] query_offset,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [lsil_pkg::CNT_BITS-1:0]         line,
    output logic [lsil_pkg::OFFSET_BITS-1:0]      column,
    output logic                                  table_overflow
);

    // Commands and status between the controller and the datapath.
    lsil_pkg::cmd_t    cmd;
    lsil_pkg::status_t status;

    // The controller owns the handshake on the request side and the search
    // sequence; it never touches payload.
    lsil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the recogniser, the table, the search registers and
    // the result register that decouples the output side.
    lsil_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .action         (action),
        .byte_value     (byte_value),
        .query_offset   (query_offset),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .line           (line),
        .column         (column),
        .table_overflow (table_overflow)
    );

endmodule

`default_nettype wire
